[src/salted_hash_range_draw_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the salted hash range draw core
// Checked in simulation; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SALTED_HASH_RANGE_DRAW_CORE_ASSERT_SVH
`define SALTED_HASH_RANGE_DRAW_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SHRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shrd: implication check failed");
`define SHRD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shrd: next-cycle check failed");
`else
`define SHRD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHRD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/shrd_pkg.sv]
// ----------------------------------------------------------------------------
// shrd_pkg
// Widths, hash constants and register codes of the salted hash range draw.
// ----------------------------------------------------------------------------
package shrd_pkg;

    localparam int ACTOR_BITS = 16;
    localparam int ROOM_BITS  = 16;
    localparam int TICK_BITS  = 32;
    localparam int SEED_BITS  = 64;
    localparam int CFG_DW     = TICK_BITS;
    localparam int CFG_AW     = 2;

    localparam logic [63:0] GOLDEN_ADD = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MUL_FIRST  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MUL_SECOND = 64'h94D0_49BB_1331_11EB;
    localparam int SHIFT_A = 30;
    localparam int SHIFT_B = 27;
    localparam int SHIFT_C = 31;

    localparam int N_LANES  = 3;
    localparam int HASH_STG = 5;
    localparam int DIV_STG  = SEED_BITS;
    localparam int N_STG    = HASH_STG + DIV_STG;

    typedef enum logic [CFG_AW-1:0] {
        REG_ACTOR = 2'd0,
        REG_ROOM  = 2'd1,
        REG_TICK  = 2'd2
    } t_reg_idx;

endpackage

[src/shrd_if.sv]
// ----------------------------------------------------------------------------
// shrd channel interfaces
// Seed input, draw result output and configuration write channel.
// ----------------------------------------------------------------------------
interface shrd_in_if import shrd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SEED_BITS-1:0] seed;
    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

interface shrd_out_if import shrd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ACTOR_BITS-1:0] culprit_index;
    logic [ROOM_BITS-1:0]  scene_index;
    logic [TICK_BITS-1:0]  event_tick;
    logic                  empty_result;
    modport source (output valid, output culprit_index, output scene_index,
                    output event_tick, output empty_result, input ready);
    modport sink   (input valid, input culprit_index, input scene_index,
                    input event_tick, input empty_result, output ready);
endinterface

interface shrd_cfg_if import shrd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] data;
    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

[src/salted_hash_range_draw_core.sv]
// Pipeline: 5 hash stages, then 64 divide stages, between seed accept and result valid.
// Throughput: one item per cycle unless o_out stalls; restoring remainder, one bit per stage.
// A full stage holds when its successor is full and stalled, so bubbles are squeezed out.
// Reset: synchronous active low; empties the pipeline and sets all three ranges to 1.
// ----------------------------------------------------------------------------
// salted_hash_range_draw_core
// Three salted SplitMix64 finalizer lanes, each reduced modulo a range register.
// ----------------------------------------------------------------------------
`include "salted_hash_range_draw_core_assert.svh"

module salted_hash_range_draw_core import shrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shrd_in_if.sink     i_in,
    shrd_out_if.source  o_out,
    shrd_cfg_if.sink    i_cfg
);

    // ---------------- configuration ----------------
    logic [ACTOR_BITS-1:0] r_actor;
    logic [ROOM_BITS-1:0]  r_room;
    logic [TICK_BITS-1:0]  r_tick;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_actor <= ACTOR_BITS'(1);
            r_room  <= ROOM_BITS'(1);
            r_tick  <= TICK_BITS'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                REG_ACTOR: r_actor <= i_cfg.data[ACTOR_BITS-1:0];
                REG_ROOM:  r_room  <= i_cfg.data[ROOM_BITS-1:0];
                REG_TICK:  r_tick  <= i_cfg.data[TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic w_empty;
    assign w_empty = (r_actor == '0) || (r_room == '0) || (r_tick == '0);

    // ---------------- valid / ready chain ----------------
    logic [N_STG-1:0] r_v;
    logic [N_STG:0]   w_rdy;

    assign i_in.ready = w_rdy[0];

    always_comb begin
        w_rdy[N_STG] = o_out.ready;
        for (int k = N_STG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < N_STG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_in.valid : r_v[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    // ---------------- hash stages ----------------
    logic [63:0] r_s0  [N_LANES];
    logic [63:0] r_ll1 [N_LANES];
    logic [31:0] r_hl1 [N_LANES];
    logic [31:0] r_lh1 [N_LANES];
    logic [63:0] r_s2  [N_LANES];
    logic [63:0] r_ll3 [N_LANES];
    logic [31:0] r_hl3 [N_LANES];
    logic [31:0] r_lh3 [N_LANES];
    logic [63:0] r_s4  [N_LANES];

    logic [63:0] n_s0 [N_LANES];
    logic [63:0] n_s2 [N_LANES];
    logic [63:0] n_s4 [N_LANES];

    always_comb begin
        logic [63:0] x;
        logic [63:0] z;
        logic [63:0] h;
        for (int l = 0; l < N_LANES; l++) begin
            x       = (i_in.seed ^ 64'(l + 1)) + GOLDEN_ADD;
            n_s0[l] = x ^ (x >> SHIFT_A);
            z       = r_ll1[l] + {r_hl1[l] + r_lh1[l], 32'h0};
            n_s2[l] = z ^ (z >> SHIFT_B);
            h       = r_ll3[l] + {r_hl3[l] + r_lh3[l], 32'h0};
            n_s4[l] = h ^ (h >> SHIFT_C);
        end
    end

    // 64x64 low product split into 32x32 partials, summed a stage later
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < N_LANES; l++) begin
            if (w_rdy[0]) r_s0[l] <= n_s0[l];
            if (w_rdy[1]) begin
                r_ll1[l] <= 64'(r_s0[l][31:0]) * 64'(MUL_FIRST[31:0]);
                r_hl1[l] <= r_s0[l][63:32] * MUL_FIRST[31:0];
                r_lh1[l] <= r_s0[l][31:0] * MUL_FIRST[63:32];
            end
            if (w_rdy[2]) r_s2[l] <= n_s2[l];
            if (w_rdy[3]) begin
                r_ll3[l] <= 64'(r_s2[l][31:0]) * 64'(MUL_SECOND[31:0]);
                r_hl3[l] <= r_s2[l][63:32] * MUL_SECOND[31:0];
                r_lh3[l] <= r_s2[l][31:0] * MUL_SECOND[63:32];
            end
            if (w_rdy[4]) r_s4[l] <= n_s4[l];
        end
    end

    // ---------------- restoring remainder stages ----------------
    logic [ACTOR_BITS-1:0] r_rem_a [DIV_STG];
    logic [ROOM_BITS-1:0]  r_rem_r [DIV_STG];
    logic [TICK_BITS-1:0]  r_rem_t [DIV_STG];
    logic [63:0]           r_dvd   [DIV_STG][N_LANES];

    for (genvar j = 0; j < DIV_STG; j++) begin : g_div
        logic [ACTOR_BITS-1:0] w_pa;
        logic [ROOM_BITS-1:0]  w_pr;
        logic [TICK_BITS-1:0]  w_pt;
        logic [63:0]           w_pd [N_LANES];
        logic [ACTOR_BITS:0]   w_ta;
        logic [ROOM_BITS:0]    w_tr;
        logic [TICK_BITS:0]    w_tt;

        always_comb begin
            for (int l = 0; l < N_LANES; l++) begin
                w_pd[l] = (j == 0) ? r_s4[l] : r_dvd[(j == 0) ? 0 : j-1][l];
            end
            w_pa = (j == 0) ? '0 : r_rem_a[(j == 0) ? 0 : j-1];
            w_pr = (j == 0) ? '0 : r_rem_r[(j == 0) ? 0 : j-1];
            w_pt = (j == 0) ? '0 : r_rem_t[(j == 0) ? 0 : j-1];
            w_ta = {w_pa, w_pd[0][63]};
            w_tr = {w_pr, w_pd[1][63]};
            w_tt = {w_pt, w_pd[2][63]};
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[HASH_STG+j]) begin
                r_rem_a[j] <= (w_ta >= {1'b0, r_actor}) ?
                              ACTOR_BITS'(w_ta - {1'b0, r_actor}) : w_ta[ACTOR_BITS-1:0];
                r_rem_r[j] <= (w_tr >= {1'b0, r_room}) ?
                              ROOM_BITS'(w_tr - {1'b0, r_room}) : w_tr[ROOM_BITS-1:0];
                r_rem_t[j] <= (w_tt >= {1'b0, r_tick}) ?
                              TICK_BITS'(w_tt - {1'b0, r_tick}) : w_tt[TICK_BITS-1:0];
                for (int l = 0; l < N_LANES; l++) begin
                    r_dvd[j][l] <= {w_pd[l][62:0], 1'b0};
                end
            end
        end
    end

    // ---------------- output ----------------
    assign o_out.valid         = r_v[N_STG-1];
    assign o_out.empty_result  = w_empty;
    assign o_out.culprit_index = w_empty ? '0 : r_rem_a[DIV_STG-1];
    assign o_out.scene_index   = w_empty ? '0 : r_rem_r[DIV_STG-1];
    assign o_out.event_tick    = w_empty ? '0 : r_rem_t[DIV_STG-1];

    // ---------------- checks ----------------
    `SHRD_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_out.valid && o_out.empty_result, (o_out.culprit_index == '0) && (o_out.scene_index == '0) && (o_out.event_tick == '0))
    `SHRD_ASSERT_IMP(a_culprit_rng, i_clk, i_rst_n, o_out.valid && !o_out.empty_result, o_out.culprit_index < r_actor)
    `SHRD_ASSERT_IMP(a_tick_rng, i_clk, i_rst_n, o_out.valid && !o_out.empty_result, (o_out.event_tick < r_tick) && (o_out.scene_index < r_room))
    `SHRD_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, r_v[0] && !w_rdy[1], r_v[0] && $stable(r_s0[0]))

endmodule
